@@ design/pbpu_pkg.sv @@
// ----------------------------------------------------------------------------
// Planar box pose update package
// Shared widths, the item kinds, the controller states, the command word
// between controller and datapath, the arctangent table and saturation.
// ----------------------------------------------------------------------------
package pbpu_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int CORDIC_STAGES = 16;

    localparam int POS_W   = 24;
    localparam int ANG_W   = 16;
    localparam int SPEED_W = 16;
    localparam int DUR_W   = 16;
    localparam int DIST_W  = SPEED_W + DUR_W;

    localparam int CZ_W   = 34;
    localparam int Z_W    = 33;
    localparam int TRIG_W = 27;
    localparam int MA_W   = (COORD_WIDTH + 1 > DIST_W + 1) ? COORD_WIDTH + 1 : DIST_W + 1;
    localparam int PW     = MA_W + TRIG_W;
    localparam int AW     = PW + 1;

    localparam int STEP_W = ($clog2(CORDIC_STAGES + 1) > 4) ? $clog2(CORDIC_STAGES + 1) : 4;
    localparam int ATAN_IDX_W = 5;
    localparam int NUM_COORDS = 8;
    localparam int CIDX_W     = 3;

    localparam logic [CZ_W-1:0]  CORDIC_GAIN      = CZ_W'(652032874);
    localparam logic [AW-1:0]    PLACE_CORNER_OFS = AW'(2560);
    localparam logic [AW-1:0]    PLACE_MID_OFS    = AW'(1280);
    localparam logic [SPEED_W-1:0] SPEED_RESET    = SPEED_W'(256);

    typedef enum logic [1:0] {
        KIND_PLACE  = 2'd0,
        KIND_ROTATE = 2'd1,
        KIND_MOVE   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CORDIC,
        ST_TRIG,
        ST_ROT,
        ST_MOVE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              place;
        logic              cordic_step;
        logic              rot_issue;
        logic              rot_write;
        logic              move_issue;
        logic              move_apply;
        logic              publish;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // Arctangent of 2^-i in units of a full turn over 2^32.
    function automatic logic signed [Z_W-1:0] atan_at(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0:    r = Z_W'(33'h020000000);
            5'd1:    r = Z_W'(33'h012E4051E);
            5'd2:    r = Z_W'(33'h009FB385B);
            5'd3:    r = Z_W'(33'h0051111D4);
            5'd4:    r = Z_W'(33'h0028B0D43);
            5'd5:    r = Z_W'(33'h00145D7E1);
            5'd6:    r = Z_W'(33'h000A2F61E);
            5'd7:    r = Z_W'(33'h000517C55);
            5'd8:    r = Z_W'(33'h00028BE53);
            5'd9:    r = Z_W'(33'h000145F2F);
            5'd10:   r = Z_W'(33'h0000A2F98);
            5'd11:   r = Z_W'(33'h0000517CC);
            5'd12:   r = Z_W'(33'h000028BE6);
            5'd13:   r = Z_W'(33'h0000145F3);
            5'd14:   r = Z_W'(33'h00000A2FA);
            5'd15:   r = Z_W'(33'h00000517D);
            5'd16:   r = Z_W'(33'h0000028BE);
            5'd17:   r = Z_W'(33'h00000145F);
            5'd18:   r = Z_W'(33'h000000A30);
            5'd19:   r = Z_W'(33'h000000518);
            5'd20:   r = Z_W'(33'h00000028C);
            5'd21:   r = Z_W'(33'h000000146);
            5'd22:   r = Z_W'(33'h0000000A3);
            5'd23:   r = Z_W'(33'h000000051);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        logic signed [COORD_WIDTH-1:0] r;
        hi = $signed((AW'(1) << (COORD_WIDTH - 1)) - AW'(1));
        lo = -hi - AW'(1);
        if (v > hi)
        begin
            r = hi[COORD_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            r = lo[COORD_WIDTH-1:0];
        end
        else
        begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/pbpu_ctrl.sv @@
// ----------------------------------------------------------------------------
// Planar box pose update controller
// Sequences one word at a time: capture, then the place write or CORDIC
// iterations and the rotate or move products, and output-register hand-off.
// ----------------------------------------------------------------------------
module pbpu_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    kind,
    output logic          out_valid,
    input  logic          out_stall,
    output pbpu_pkg::cmd_t cmd
);
    import pbpu_pkg::*;

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_NONE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.step       = cnt_reg;
        in_stall       = 1'b1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    kind_next  = kind_t'(kind);
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cnt_next = '0;
                case (kind_reg)
                    KIND_PLACE:
                    begin
                        cmd.place  = 1'b1;
                        state_next = ST_DONE;
                    end
                    KIND_ROTATE, KIND_MOVE:
                    begin
                        state_next = ST_CORDIC;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STAGES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_TRIG;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            ST_TRIG:
            begin
                // Sine and cosine settle into their registers here.
                state_next = (kind_reg == KIND_ROTATE) ? ST_ROT : ST_MOVE;
            end
            ST_ROT:
            begin
                cmd.rot_issue = (cnt_reg < STEP_W'(NUM_COORDS));
                cmd.rot_write = (cnt_reg != '0);
                if (cnt_reg == STEP_W'(NUM_COORDS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            ST_MOVE:
            begin
                if (cnt_reg == '0)
                begin
                    cmd.move_issue = 1'b1;
                    cnt_next       = STEP_W'(1);
                end
                else
                begin
                    cmd.move_apply = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/pbpu_dp.sv @@
// ----------------------------------------------------------------------------
// Planar box pose update datapath
// Pose registers, an iterative CORDIC unit, two shared multipliers for the
// rotation and move products, and the output word register.
// ----------------------------------------------------------------------------
module pbpu_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pbpu_pkg::cmd_t                        cmd,
    input  logic                                  cfg_wr_en,
    input  logic [pbpu_pkg::SPEED_W-1:0]          cfg_wr_data,
    input  logic [1:0]                            kind,
    input  logic signed [pbpu_pkg::POS_W-1:0]     pos_x,
    input  logic signed [pbpu_pkg::POS_W-1:0]     pos_y,
    input  logic signed [pbpu_pkg::ANG_W-1:0]     turn_angle,
    input  logic [pbpu_pkg::DUR_W-1:0]            duration,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_left_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_left_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_right_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_right_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_left_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_left_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_right_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_right_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] mid_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] mid_y,
    output logic [pbpu_pkg::ANG_W-1:0]            heading
);
    import pbpu_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0]     corner_reg [NUM_COORDS];
    logic signed [CW-1:0]     corner_next [NUM_COORDS];
    logic signed [CW-1:0]     center_reg [2];
    logic signed [CW-1:0]     center_next [2];
    logic [ANG_W-1:0]         heading_reg, heading_next;
    logic [SPEED_W-1:0]       speed_reg;

    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [DUR_W-1:0]         dur_reg;

    logic signed [CZ_W-1:0]   x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic                     flip_reg;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;

    logic signed [PW-1:0]     prod0_reg, prod1_reg;
    logic [CIDX_W-1:0]        prod_idx_reg;

    logic signed [CW-1:0]     out_reg [NUM_COORDS + 2];
    logic [ANG_W-1:0]         out_heading_reg;

    // CORDIC start values
    logic [ANG_W-1:0]         ang_sel;
    logic [31:0]              z32;
    logic                     flip_in;

    always_comb
    begin
        ang_sel = (kind_t'(kind) == KIND_ROTATE) ? turn_angle : heading_reg;
        z32     = {ang_sel, 16'd0};
        flip_in = (ang_sel[15:14] == 2'd1) || (ang_sel[15:14] == 2'd2);
        if (flip_in)
        begin
            z32[31] = ~z32[31];
        end
    end

    // CORDIC iteration and result rounding
    logic signed [CZ_W-1:0]   xs, ys, xr, yr;
    logic signed [TRIG_W-1:0] c_raw, s_raw;

    always_comb
    begin
        xs    = x_reg >>> cmd.step;
        ys    = y_reg >>> cmd.step;
        xr    = (x_reg + $signed(CZ_W'(32))) >>> 6;
        yr    = (y_reg + $signed(CZ_W'(32))) >>> 6;
        c_raw = xr[TRIG_W-1:0];
        s_raw = yr[TRIG_W-1:0];
    end

    // Product operands
    logic signed [AW-1:0]   diff_x, diff_y;
    logic signed [MA_W-1:0] opa, opb;
    logic [CIDX_W-1:0]      cidx;
    logic                   is_x;

    always_comb
    begin
        cidx   = cmd.step[CIDX_W-1:0];
        is_x   = ~cidx[0];
        diff_x = AW'(corner_reg[{cidx[CIDX_W-1:1], 1'b0}]) - AW'(center_reg[0]);
        diff_y = AW'(corner_reg[{cidx[CIDX_W-1:1], 1'b1}]) - AW'(center_reg[1]);
        if (cmd.move_issue)
        begin
            opa = $signed(MA_W'(dist_reg));
            opb = $signed(MA_W'(dist_reg));
        end
        else if (is_x)
        begin
            opa = diff_x[MA_W-1:0];
            opb = diff_y[MA_W-1:0];
        end
        else
        begin
            opa = diff_y[MA_W-1:0];
            opb = diff_x[MA_W-1:0];
        end
    end

    // Rotation write-back and move offsets
    logic signed [AW-1:0] rot_sum, rot_new, dx, dy;
    logic                 wr_x;

    always_comb
    begin
        wr_x    = ~prod_idx_reg[0];
        rot_sum = wr_x ? (AW'(prod0_reg) - AW'(prod1_reg)) : (AW'(prod0_reg) + AW'(prod1_reg));
        rot_new = ((rot_sum + $signed(AW'(1) <<< 23)) >>> 24)
                  + (wr_x ? AW'(center_reg[0]) : AW'(center_reg[1]));
        dx      = (AW'(prod0_reg) + $signed(AW'(1) <<< 31)) >>> 32;
        dy      = (AW'(prod1_reg) + $signed(AW'(1) <<< 31)) >>> 32;
    end

    // Pose next values
    logic signed [AW-1:0] pxe, pye;

    always_comb
    begin
        pxe          = AW'(px_reg);
        pye          = AW'(py_reg);
        corner_next  = corner_reg;
        center_next  = center_reg;
        heading_next = heading_reg;
        if (cmd.load && (kind_t'(kind) == KIND_ROTATE))
        begin
            heading_next = heading_reg + turn_angle;
        end
        if (cmd.place)
        begin
            corner_next[0] = sat_coord(pxe);
            corner_next[1] = sat_coord(pye);
            corner_next[2] = sat_coord(pxe - PLACE_CORNER_OFS);
            corner_next[3] = sat_coord(pye);
            corner_next[4] = sat_coord(pxe);
            corner_next[5] = sat_coord(pye - PLACE_CORNER_OFS);
            corner_next[6] = sat_coord(pxe - PLACE_CORNER_OFS);
            corner_next[7] = sat_coord(pye - PLACE_CORNER_OFS);
            center_next[0] = sat_coord(pxe - PLACE_MID_OFS);
            center_next[1] = sat_coord(pye - PLACE_MID_OFS);
        end
        if (cmd.rot_write)
        begin
            corner_next[prod_idx_reg] = sat_coord(rot_new);
        end
        if (cmd.move_apply)
        begin
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                corner_next[k] = sat_coord(AW'(corner_reg[k]) + (k[0] ? dy : dx));
            end
            center_next[0] = sat_coord(AW'(center_reg[0]) + dx);
            center_next[1] = sat_coord(AW'(center_reg[1]) + dy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                corner_reg[k] <= '0;
            end
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            heading_reg   <= '0;
            speed_reg     <= SPEED_RESET;
        end
        else
        begin
            corner_reg  <= corner_next;
            center_reg  <= center_next;
            heading_reg <= heading_next;
            if (cfg_wr_en)
            begin
                speed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            dur_reg  <= duration;
            x_reg    <= $signed(CORDIC_GAIN);
            y_reg    <= '0;
            z_reg    <= Z_W'($signed(z32));
            flip_reg <= flip_in;
        end
        else if (cmd.cordic_step)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_at(ATAN_IDX_W'(cmd.step));
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_at(ATAN_IDX_W'(cmd.step));
            end
        end

        dist_reg <= speed_reg * dur_reg;
        cos_reg  <= flip_reg ? -c_raw : c_raw;
        sin_reg  <= flip_reg ? -s_raw : s_raw;

        if (cmd.rot_issue || cmd.move_issue)
        begin
            prod0_reg    <= opa * cos_reg;
            prod1_reg    <= opb * sin_reg;
            prod_idx_reg <= cidx;
        end

        if (cmd.publish)
        begin
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                out_reg[k] <= corner_reg[k];
            end
            out_reg[NUM_COORDS]     <= center_reg[0];
            out_reg[NUM_COORDS + 1] <= center_reg[1];
            out_heading_reg         <= heading_reg;
        end
    end

    assign front_left_x  = out_reg[0];
    assign front_left_y  = out_reg[1];
    assign front_right_x = out_reg[2];
    assign front_right_y = out_reg[3];
    assign back_left_x   = out_reg[4];
    assign back_left_y   = out_reg[5];
    assign back_right_x  = out_reg[6];
    assign back_right_y  = out_reg[7];
    assign mid_x         = out_reg[NUM_COORDS];
    assign mid_y         = out_reg[NUM_COORDS + 1];
    assign heading       = out_heading_reg;

endmodule

@@ design/planar_box_pose_update.sv @@
// ----------------------------------------------------------------------------
// Planar box pose update
// Keeps a square box pose (four corners, center, heading) and updates it
// by place, rotate or move words.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry kind, pos_x, pos_y, turn_angle and
// duration; a word is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall carry the whole pose after the update,
// one result word for every input word.
// The user must write the speed register via cfg_wr_en/cfg_wr_data only
// while idle; the block does not enforce it. One word is processed at a
// time. A place word or an unused kind goes from dispatch to the output
// register; rotate and move run the CORDIC unit at one stage per cycle
// (16 stages), then one product pair per coordinate (rotate) or one pair
// (move) on two shared multipliers. The finished pose sits in an output
// register, so a new word is accepted while the previous result waits; a
// result held by out_stall blocks only the next hand-off. Reset clears the
// pose and heading to zero, sets speed to 1.0 and leaves both channels empty.
// ----------------------------------------------------------------------------
module planar_box_pose_update
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [pbpu_pkg::SPEED_W-1:0]          cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            kind,
    input  logic signed [pbpu_pkg::POS_W-1:0]     pos_x,
    input  logic signed [pbpu_pkg::POS_W-1:0]     pos_y,
    input  logic signed [pbpu_pkg::ANG_W-1:0]     turn_angle,
    input  logic [pbpu_pkg::DUR_W-1:0]            duration,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_left_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_left_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_right_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] front_right_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_left_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_left_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_right_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] back_right_y,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] mid_x,
    output logic signed [pbpu_pkg::COORD_WIDTH-1:0] mid_y,
    output logic [pbpu_pkg::ANG_W-1:0]            heading
);
    import pbpu_pkg::*;

    cmd_t cmd;

    pbpu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pbpu_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .kind          (kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .turn_angle    (turn_angle),
        .duration      (duration),
        .front_left_x  (front_left_x),
        .front_left_y  (front_left_y),
        .front_right_x (front_right_x),
        .front_right_y (front_right_y),
        .back_left_x   (back_left_x),
        .back_left_y   (back_left_y),
        .back_right_x  (back_right_x),
        .back_right_y  (back_right_y),
        .mid_x         (mid_x),
        .mid_y         (mid_y),
        .heading       (heading)
    );

endmodule
